// ===== sv/tcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet command stripper package
// Protocol codes, parser phases, the reply burst type and the preferred-name lookup.
// ----------------------------------------------------------------------------
package tcs_pkg;
    localparam logic [7:0] IAC  = 8'd255;
    localparam logic [7:0] DONT = 8'd254;
    localparam logic [7:0] DO   = 8'd253;
    localparam logic [7:0] WONT = 8'd252;
    localparam logic [7:0] WILL = 8'd251;
    localparam logic [7:0] SB   = 8'd250;
    localparam logic [7:0] NOP  = 8'd241;
    localparam logic [7:0] SE   = 8'd240;
    localparam logic [7:0] FEAT_ECHO  = 8'd1;
    localparam logic [7:0] FEAT_SGA   = 8'd3;
    localparam logic [7:0] FEAT_TTYPE = 8'd24;
    localparam logic [7:0] TT_SEND = 8'd1;
    localparam logic [7:0] TT_IS   = 8'd0;
    localparam logic [7:0] CH_NL   = 8'd10;

    localparam logic [2:0] PH_NORMAL  = 3'd0;
    localparam logic [2:0] PH_IAC     = 3'd1;
    localparam logic [2:0] PH_NEG     = 3'd2;
    localparam logic [2:0] PH_SBFEAT  = 3'd3;
    localparam logic [2:0] PH_SUB     = 3'd4;
    localparam logic [2:0] PH_SUBIAC  = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;
    localparam logic [2:0] PH_SKIPIAC = 3'd7;

    localparam int MAXRES = 8;

    // One burst of results caused by one input item.
    typedef struct packed {
        logic [3:0]      count;
        logic [7:0]      dmask;
        logic [7:0][7:0] bytes;
        logic            incompatible;
    } t_burst;

    // Preferred name byte at a position, 0 past its length.
    function automatic logic [7:0] pref_byte(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] b;
        b = 8'd0;
        unique case (k)
            2'd0: begin
                unique case (i)
                    3'd0: b = 8'h41; 3'd1: b = 8'h4E; 3'd2: b = 8'h53; 3'd3: b = 8'h49;
                    default: b = 8'd0;
                endcase
            end
            default: begin
                unique case (i)
                    3'd0: b = 8'h56; 3'd1: b = 8'h54; 3'd2: b = 8'h31; 3'd3: b = 8'h30;
                    3'd4: b = (k == 2'd1) ? 8'h30 : 8'h32;
                    default: b = 8'd0;
                endcase
            end
        endcase
        return b;
    endfunction
endpackage

// ===== sv/tcs_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet command stripper output queue
// Holds reply bursts and serializes them one byte per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module tcs_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcs_pkg::t_burst i_burst,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_dest,
    output logic [7:0]     o_out_byte,
    output logic           o_last,
    output logic           o_incompatible
);
    // Two-entry burst queue.
    tcs_pkg::t_burst r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [2:0] r_pos;
    logic       pop_b;
    logic [2:0] cnt_after;
    tcs_pkg::t_burst h;

    assign h       = r_q[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_dest  = h.dmask[r_pos];
    assign o_out_byte = h.bytes[r_pos];
    assign o_last  = ({1'b0, r_pos} == h.count - 4'd1);
    assign o_incompatible = h.incompatible;
    assign pop_b = o_valid && !i_stall && o_last;

    // Full means the queue will have no free entry after this edge, so a
    // burst pushed in the following cycle would find no room.
    assign cnt_after = {1'b0, r_cnt} + {2'b00, i_push} - {2'b00, pop_b};
    assign o_full    = (cnt_after >= 3'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_burst;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0; r_pos <= 3'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (o_valid && !i_stall) begin
                if (o_last) begin
                    r_rp <= ~r_rp; r_pos <= 3'd0;
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop_b};
        end
    end
endmodule

// ===== sv/telnet_command_stripper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet command stripper
// Strips Telnet commands from received bytes and answers option negotiation.
// ----------------------------------------------------------------------------
// An item is registered in stage 1 together with the read of the name
// memory, and its results are then pushed into the reply queue.
// The block takes one item per cycle while the reply queue has room; the
// results of a burst leave the output port one at a time.
// Reset (synchronous, active low) clears all control state; the name
// memory is not cleared, only entries already written are ever compared.
// ----------------------------------------------------------------------------
module telnet_command_stripper #(
    parameter int NAME_DEPTH = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_chunk_start,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_keepalive_period,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_dest,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_incompatible
);
    localparam int AW = $clog2(2 * NAME_DEPTH);
    localparam logic [5:0] DEPTH6 = 6'(NAME_DEPTH);

    // The name memory: two banks, the stored name and the incoming one.
    logic [7:0] r_mem [2 * NAME_DEPTH];
    logic [7:0] r_rd;

    logic [31:0] r_period, r_ticks;
    logic [2:0]  r_phase;
    logic [7:0]  r_pcmd, r_cnt;
    logic        r_bank, r_same, r_incomp;
    logic [5:0]  r_slen;
    logic [2:0]  r_pmatch;

    // Stage-1 item register.
    logic        r_v, r_act, r_cs;
    logic [7:0]  r_b;

    logic full;
    tcs_pkg::t_burst bu;

    assign o_cfg_ready = 1'b1;
    // The front takes a new item whenever the queue can absorb the current.
    assign o_stall = full;
    logic acc;
    assign acc = i_valid && !full;

    // Read address: the stored bank entry for the byte this item may be.
    // The address uses the state as it stands after the item now in stage 1,
    // so the count is forwarded when that item advances it.
    logic [7:0] cnt_next;
    logic       bank_next;
    logic [AW-1:0] rd_addr;
    logic [7:0] ri;
    always_comb begin
        ri = cnt_next - 8'd1;
        if (ri >= 8'(NAME_DEPTH)) ri = 8'd0;
        rd_addr = AW'({24'd0, bank_next} * NAME_DEPTH + {24'd0, ri});
    end

    always_ff @(posedge i_clk) r_rd <= r_mem[rd_addr];

    // Per-item processing in stage 1.
    logic [2:0]  n_phase;
    logic [7:0]  n_pcmd, n_cnt;
    logic        n_bank, n_same, n_incomp;
    logic [5:0]  n_slen;
    logic [2:0]  n_pmatch;
    logic [31:0] n_ticks;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [3:0]  nres;
    logic [7:0]  dm;
    logic [7:0][7:0] by;

    function automatic void put(inout logic [3:0] n, inout logic [7:0] d,
                                inout logic [7:0][7:0] bb, input logic dst,
                                input logic [7:0] v);
        if (n < 4'd8) begin
            bb[n[2:0]] = v; d[n[2:0]] = dst; n = n + 4'd1;
        end
    endfunction

    always_comb begin
        logic [7:0] i;
        logic       pref;
        logic       sub, fe;
        logic [5:0] len;
        logic [2:0] pk;
        n_phase = r_phase; n_pcmd = r_pcmd; n_cnt = r_cnt; n_bank = r_bank;
        n_same = r_same; n_slen = r_slen; n_pmatch = r_pmatch; n_incomp = r_incomp;
        n_ticks = r_ticks; wr_en = 1'b0; wr_addr = '0;
        nres = 4'd0; dm = 8'd0; by = '0; sub = 1'b0; fe = 1'b0;
        i = r_cnt - 8'd1; pref = 1'b0; len = 6'd0; pk = 3'd0;
        if (r_v) begin
            if (r_act) begin
                if (r_ticks != 32'hFFFF_FFFF) n_ticks = r_ticks + 32'd1;
            end else begin
                if (r_cs && r_ticks > r_period) begin
                    n_ticks = 32'd0;
                    put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                    put(nres, dm, by, 1'b1, tcs_pkg::NOP);
                end
                unique case (r_phase)
                    tcs_pkg::PH_NORMAL: begin
                        if (r_b == tcs_pkg::IAC) n_phase = tcs_pkg::PH_IAC;
                        else put(nres, dm, by, 1'b0, (r_b == 8'd0) ? tcs_pkg::CH_NL : r_b);
                    end
                    tcs_pkg::PH_IAC: begin
                        if (r_b == tcs_pkg::IAC) begin
                            put(nres, dm, by, 1'b0, tcs_pkg::IAC);
                            n_phase = tcs_pkg::PH_NORMAL;
                        end else fe = 1'b1;
                    end
                    tcs_pkg::PH_NEG: begin
                        n_phase = tcs_pkg::PH_NORMAL;
                        if (r_b == tcs_pkg::FEAT_ECHO) begin
                            if (r_pcmd == tcs_pkg::WILL) begin
                                n_incomp = 1'b1;
                                put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                put(nres, dm, by, 1'b1, tcs_pkg::DONT);
                                put(nres, dm, by, 1'b1, r_b);
                            end else if (r_pcmd == tcs_pkg::DO || r_pcmd == tcs_pkg::DONT) begin
                                put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                put(nres, dm, by, 1'b1, tcs_pkg::WILL);
                                put(nres, dm, by, 1'b1, r_b);
                            end
                        end else if (r_b == tcs_pkg::FEAT_SGA) begin
                            if (r_pcmd == tcs_pkg::DO || r_pcmd == tcs_pkg::DONT) begin
                                put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                put(nres, dm, by, 1'b1, (r_pcmd == tcs_pkg::DO) ?
                                    tcs_pkg::WILL : tcs_pkg::WONT);
                                put(nres, dm, by, 1'b1, r_b);
                            end
                        end else if (r_b == tcs_pkg::FEAT_TTYPE) begin
                            if (r_pcmd == tcs_pkg::WILL) begin
                                if (r_slen == 6'd0) begin
                                    put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                    put(nres, dm, by, 1'b1, tcs_pkg::SB);
                                    put(nres, dm, by, 1'b1, tcs_pkg::FEAT_TTYPE);
                                    put(nres, dm, by, 1'b1, tcs_pkg::TT_SEND);
                                    put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                    put(nres, dm, by, 1'b1, tcs_pkg::SE);
                                end
                            end else if (r_pcmd == tcs_pkg::DO || r_pcmd == tcs_pkg::DONT) begin
                                put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                put(nres, dm, by, 1'b1, tcs_pkg::WONT);
                                put(nres, dm, by, 1'b1, r_b);
                            end
                        end
                    end
                    tcs_pkg::PH_SBFEAT: begin
                        n_cnt = 8'd0; n_same = 1'b1; n_pmatch = 3'b111;
                        n_phase = (r_b == tcs_pkg::FEAT_TTYPE) ?
                            tcs_pkg::PH_SUB : tcs_pkg::PH_SKIP;
                    end
                    tcs_pkg::PH_SUB, tcs_pkg::PH_SKIP: begin
                        if (r_b == tcs_pkg::IAC) n_phase = r_phase + 3'd1;
                        else sub = (r_phase == tcs_pkg::PH_SUB);
                    end
                    default: begin
                        if (r_b == tcs_pkg::IAC) begin
                            n_phase = r_phase - 3'd1;
                            sub = (r_phase == tcs_pkg::PH_SUBIAC);
                        end else if (r_b == tcs_pkg::SE) begin
                            n_phase = tcs_pkg::PH_NORMAL;
                            if (r_phase == tcs_pkg::PH_SUBIAC && r_cnt > 8'd2) begin
                                len = (r_cnt - 8'd1 > 8'(NAME_DEPTH)) ? DEPTH6 :
                                      6'(r_cnt - 8'd1);
                                if (!(r_same && len == r_slen)) begin
                                    n_bank = ~r_bank; n_slen = len;
                                    if (r_pmatch[0] && len == 6'd4) pref = 1'b1;
                                    if (r_pmatch[1] && len == 6'd5) pref = 1'b1;
                                    if (r_pmatch[2] && len == 6'd5) pref = 1'b1;
                                    if (!pref) begin
                                        put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                        put(nres, dm, by, 1'b1, tcs_pkg::SB);
                                        put(nres, dm, by, 1'b1, tcs_pkg::FEAT_TTYPE);
                                        put(nres, dm, by, 1'b1, tcs_pkg::TT_SEND);
                                        put(nres, dm, by, 1'b1, tcs_pkg::IAC);
                                        put(nres, dm, by, 1'b1, tcs_pkg::SE);
                                    end
                                end
                            end
                        end else fe = 1'b1;
                    end
                endcase
                if (fe) begin
                    if (r_b == tcs_pkg::SB) n_phase = tcs_pkg::PH_SBFEAT;
                    else if (r_b >= tcs_pkg::WILL && r_b <= tcs_pkg::DONT) begin
                        n_pcmd = r_b; n_phase = tcs_pkg::PH_NEG;
                    end else n_phase = tcs_pkg::PH_NORMAL;
                end
                if (sub) begin
                    if (r_cnt == 8'd0) begin
                        if (r_b != tcs_pkg::TT_IS) n_phase = tcs_pkg::PH_SKIP;
                        else n_cnt = 8'd1;
                    end else begin
                        if (i < 8'(NAME_DEPTH)) begin
                            wr_en = 1'b1;
                            wr_addr = AW'({24'd0, ~r_bank} * NAME_DEPTH + {24'd0, i});
                            if (i >= {2'b00, r_slen} || r_rd != r_b) n_same = 1'b0;
                        end
                        for (int k = 0; k < 3; k++) begin
                            if (i >= ((k == 0) ? 8'd4 : 8'd5) ||
                                tcs_pkg::pref_byte(2'(k), i[2:0]) != r_b)
                                pk[k] = 1'b1;
                        end
                        n_pmatch = r_pmatch & ~pk;
                        if (r_cnt != 8'd255) n_cnt = r_cnt + 8'd1;
                    end
                end
            end
        end
        bu.count = nres; bu.dmask = dm; bu.bytes = by; bu.incompatible = n_incomp;
    end

    // Forwarded count and bank for the read of the next item.
    assign cnt_next  = n_cnt;
    assign bank_next = n_bank;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= r_b;
        if (acc) begin
            r_act <= i_action; r_b <= i_rx_byte; r_cs <= i_chunk_start;
        end
        if (!i_rst_n) begin
            r_v <= 1'b0; r_period <= 32'd5000; r_ticks <= 32'hFFFF_FFFF;
            r_phase <= tcs_pkg::PH_NORMAL; r_pcmd <= 8'd0; r_cnt <= 8'd0;
            r_bank <= 1'b0; r_same <= 1'b1; r_slen <= 6'd0; r_pmatch <= 3'b111;
            r_incomp <= 1'b0;
        end else begin
            if (i_cfg_valid) r_period <= i_keepalive_period;
            r_v <= acc;
            r_phase <= n_phase; r_pcmd <= n_pcmd; r_cnt <= n_cnt; r_bank <= n_bank;
            r_same <= n_same; r_slen <= n_slen; r_pmatch <= n_pmatch;
            r_incomp <= n_incomp; r_ticks <= n_ticks;
        end
    end

    // The queue reports full when it will have no free entry after this edge,
    // taking the push from stage 1 and the pop at the output into account.
    // An item accepted now pushes from stage 1 in the following cycle and always finds room.
    logic qfull;
    tcs_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(r_v && bu.count != 4'd0), .i_burst(bu), .o_full(qfull),
        .o_valid(o_valid), .i_stall(i_stall), .o_dest(o_dest),
        .o_out_byte(o_out_byte), .o_last(o_last), .o_incompatible(o_incompatible)
    );
    assign full = qfull;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet command stripper testbench
// Drives received bytes and ticks with random gaps on both sides, predicts
// the console data and client replies in a local parser model and compares
// every result item field by field in the order the block sends them.
// ----------------------------------------------------------------------------
module tb;
    localparam int NAME_LEN = 40;
    localparam int IDLE_LIMIT = 3000;

    // One expected result item.
    typedef struct {
        logic       dest;
        logic [7:0] data;
        logic       last;
        logic       incomp;
    } t_reply;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_chunk_start = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_keepalive_period = 32'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_dest;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_incompatible;

    telnet_command_stripper uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_rx_byte          (i_rx_byte),
        .i_chunk_start      (i_chunk_start),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_keepalive_period (i_keepalive_period),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_dest             (o_dest),
        .o_out_byte         (o_out_byte),
        .o_last             (o_last),
        .o_incompatible     (o_incompatible)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the parser state.
    logic [2:0]  phase;
    logic [7:0]  pend_cmd;
    logic [7:0]  sub_feat;
    logic [7:0]  sub_cnt;
    logic [7:0]  names [0:2*NAME_LEN-1];
    logic        bank;
    logic [5:0]  name_len;
    logic        same_name;
    logic [2:0]  pref_hit;
    logic [31:0] ticks;
    logic        incompat;
    logic [31:0] period;

    // Preferred terminal names: ANSI, VT100, VT102.
    logic [7:0] pref_chr [0:2][0:4] = '{'{8'h41, 8'h4E, 8'h53, 8'h49, 8'h00},
                                        '{8'h56, 8'h54, 8'h31, 8'h30, 8'h30},
                                        '{8'h56, 8'h54, 8'h31, 8'h30, 8'h32}};
    int pref_size [0:2] = '{4, 5, 5};

    t_reply replies_due[$];
    t_reply burst[$];

    int items_sent = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit tx_busy_mode = 1'b0;
    bit rx_busy_mode = 1'b0;

    task automatic put(input logic dest, input logic [7:0] b);
        t_reply r;
        r.dest = dest;
        r.data = b;
        r.last = 1'b0;
        r.incomp = 1'b0;
        if (burst.size() < tcs_pkg::MAXRES) burst.push_back(r);
    endtask

    task automatic ask_next_name();
        put(1'b1, tcs_pkg::IAC); put(1'b1, tcs_pkg::SB); put(1'b1, tcs_pkg::FEAT_TTYPE);
        put(1'b1, tcs_pkg::TT_SEND); put(1'b1, tcs_pkg::IAC); put(1'b1, tcs_pkg::SE);
    endtask

    task automatic answer(input logic [7:0] req, input logic [7:0] feat);
        logic [7:0] verb;
        bit         reply;
        reply = 1'b0;
        verb = 8'd0;
        if (feat == tcs_pkg::FEAT_ECHO) begin
            if (req == tcs_pkg::WILL) begin
                incompat = 1'b1;
                reply = 1'b1; verb = tcs_pkg::DONT;
            end else if (req == tcs_pkg::DO || req == tcs_pkg::DONT) begin
                reply = 1'b1; verb = tcs_pkg::WILL;
            end
        end else if (feat == tcs_pkg::FEAT_SGA) begin
            if (req == tcs_pkg::DO) begin
                reply = 1'b1; verb = tcs_pkg::WILL;
            end else if (req == tcs_pkg::DONT) begin
                reply = 1'b1; verb = tcs_pkg::WONT;
            end
        end else if (feat == tcs_pkg::FEAT_TTYPE) begin
            if (req == tcs_pkg::WILL) begin
                if (name_len == 0) ask_next_name();
            end else if (req == tcs_pkg::DO || req == tcs_pkg::DONT) begin
                reply = 1'b1; verb = tcs_pkg::WONT;
            end
        end
        if (reply) begin
            put(1'b1, tcs_pkg::IAC); put(1'b1, verb); put(1'b1, feat);
        end
    endtask

    task automatic command_byte(input logic [7:0] b);
        if (b == tcs_pkg::SB) begin
            phase = tcs_pkg::PH_SBFEAT;
        end else if (b >= tcs_pkg::WILL && b <= tcs_pkg::DONT) begin
            pend_cmd = b;
            phase = tcs_pkg::PH_NEG;
        end else begin
            phase = tcs_pkg::PH_NORMAL;
        end
    endtask

    task automatic name_byte(input logic [7:0] b);
        int idx;
        if (phase != tcs_pkg::PH_SUB) return;
        if (sub_cnt == 0) begin
            if (b != tcs_pkg::TT_IS) phase = tcs_pkg::PH_SKIP;
            else sub_cnt = 8'd1;
            return;
        end
        idx = int'(sub_cnt) - 1;
        if (idx < NAME_LEN) begin
            names[(bank ^ 1'b1) * NAME_LEN + idx] = b;
            if (idx >= int'(name_len)) same_name = 1'b0;
            else if (names[bank * NAME_LEN + idx] != b) same_name = 1'b0;
        end
        for (int k = 0; k < 3; k++) begin
            if (idx >= pref_size[k]) pref_hit[k] = 1'b0;
            else if (pref_chr[k][idx] != b) pref_hit[k] = 1'b0;
        end
        if (sub_cnt != 8'd255) sub_cnt++;
    endtask

    task automatic name_done();
        int  n;
        bit  known;
        known = 1'b0;
        if (sub_cnt <= 2) return;
        n = int'(sub_cnt) - 1;
        if (n > NAME_LEN) n = NAME_LEN;
        if (same_name && n == int'(name_len)) return;
        bank ^= 1'b1;
        name_len = n[5:0];
        for (int k = 0; k < 3; k++)
            if (pref_hit[k] && n == pref_size[k]) known = 1'b1;
        if (!known) ask_next_name();
    endtask

    // Works out the results of one accepted item and queues them.
    task automatic predict_replies(input logic act, input logic [7:0] b, input logic cs);
        burst.delete();
        if (act) begin
            if (ticks != 32'hFFFF_FFFF) ticks++;
            return;
        end
        if (cs && ticks > period) begin
            ticks = 32'd0;
            put(1'b1, tcs_pkg::IAC);
            put(1'b1, tcs_pkg::NOP);
        end
        case (phase)
            tcs_pkg::PH_NORMAL: begin
                if (b == tcs_pkg::IAC) phase = tcs_pkg::PH_IAC;
                else put(1'b0, (b == 8'd0) ? tcs_pkg::CH_NL : b);
            end
            tcs_pkg::PH_IAC: begin
                if (b == tcs_pkg::IAC) begin
                    put(1'b0, tcs_pkg::IAC);
                    phase = tcs_pkg::PH_NORMAL;
                end else begin
                    command_byte(b);
                end
            end
            tcs_pkg::PH_NEG: begin
                answer(pend_cmd, b);
                phase = tcs_pkg::PH_NORMAL;
            end
            tcs_pkg::PH_SBFEAT: begin
                sub_feat = b;
                sub_cnt = 8'd0;
                same_name = 1'b1;
                pref_hit = 3'b111;
                phase = (b == tcs_pkg::FEAT_TTYPE) ? tcs_pkg::PH_SUB : tcs_pkg::PH_SKIP;
            end
            tcs_pkg::PH_SUB, tcs_pkg::PH_SKIP: begin
                if (b == tcs_pkg::IAC) phase = phase + 3'd1;
                else name_byte(b);
            end
            default: begin
                if (b == tcs_pkg::IAC) begin
                    phase = phase - 3'd1;
                    name_byte(b);
                end else if (b == tcs_pkg::SE) begin
                    if (phase == tcs_pkg::PH_SUBIAC) name_done();
                    phase = tcs_pkg::PH_NORMAL;
                end else begin
                    command_byte(b);
                end
            end
        endcase
        foreach (burst[k]) begin
            burst[k].last = (k == burst.size() - 1);
            burst[k].incomp = incompat;
            replies_due.push_back(burst[k]);
        end
    endtask

    // Sends one item after a random gap and predicts it once accepted.
    task automatic send_item(input logic act, input logic [7:0] b, input logic cs);
        int gap;
        gap = tx_busy_mode ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_action = act;
        i_rx_byte = b;
        i_chunk_start = cs;
        do @(posedge i_clk); while (o_stall);
        predict_replies(act, b, cs);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(1'b0, b, ($urandom_range(0, 7) == 0));
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom), 1'($urandom));
    endtask

    // Holds off until every queued reply has come out, then lets the block settle.
    task automatic drain();
        i_valid = 1'b0;
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_period(input logic [31:0] v);
        drain();
        i_cfg_valid = 1'b1;
        i_keepalive_period = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        period = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_cmd(input logic [7:0] req, input logic [7:0] feat);
        send_rx(tcs_pkg::IAC); send_rx(req); send_rx(feat);
    endtask

    task automatic send_ttype(input t_byte_q name);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SB); send_rx(tcs_pkg::FEAT_TTYPE);
        send_rx(tcs_pkg::TT_IS);
        foreach (name[k]) begin
            send_rx(name[k]);
            if (name[k] == tcs_pkg::IAC) send_rx(tcs_pkg::IAC);
        end
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SE);
    endtask

    function automatic t_byte_q pick_name();
        t_byte_q q;
        int sel;
        int n;
        sel = $urandom_range(0, 5);
        case (sel)
            0: q = '{8'h41, 8'h4E, 8'h53, 8'h49};
            1: q = '{8'h56, 8'h54, 8'h31, 8'h30, 8'h30};
            2: q = '{8'h56, 8'h54, 8'h31, 8'h30, 8'h32};
            3: q = '{8'h78, 8'h74, 8'h65, 8'h72, 8'h6D};
            default: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(38, 46)
                                                : $urandom_range(0, 7);
                for (int k = 0; k < n; k++) q.push_back(8'($urandom));
            end
        endcase
        return q;
    endfunction

    // Result check and receiver stalls.
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_valid && !i_stall) begin
            replies_seen++;
            rx_wait = rx_busy_mode ? 0 : $urandom_range(0, 8);
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: dest=%0d byte=%0d last=%0d inc=%0d",
                             o_dest, o_out_byte, o_last, o_incompatible);
            end else begin
                e = replies_due.pop_front();
                if (o_dest !== e.dest || o_out_byte !== e.data ||
                    o_last !== e.last || o_incompatible !== e.incomp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected dest=%0d byte=%0d last=%0d inc=%0d, %s",
                                 e.dest, e.data, e.last, e.incomp, $sformatf(
                                 "got dest=%0d byte=%0d last=%0d inc=%0d",
                                 o_dest, o_out_byte, o_last, o_incompatible));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            i_stall = 1'b1;
            rx_wait--;
        end else begin
            i_stall = 1'b0;
        end
    end

    // Watchdog: ends the run after a long stretch with no accepted item, result or configuration write.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d results still due", replies_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_data_path();
        send_item(1'b0, 8'h41, 1'b1);   // saturated tick count, keepalive first
        send_rx(8'h00);
        send_rx(8'h7F);
        send_rx(8'h80);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::IAC);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::NOP);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SE);
        send_item(1'b0, 8'h42, 1'b1);   // count was cleared, no keepalive now
    endtask

    task automatic test_negotiation();
        logic [7:0] feats [4] = '{tcs_pkg::FEAT_SGA, tcs_pkg::FEAT_TTYPE, 8'd5,
                                  tcs_pkg::FEAT_ECHO};
        foreach (feats[f])
            for (int r = tcs_pkg::WILL; r <= tcs_pkg::DONT; r++) send_cmd(8'(r), feats[f]);
    endtask

    task automatic test_subnegotiation();
        t_byte_q nm;
        drain();
        nm = '{8'h78, 8'h74, 8'h65, 8'h72, 8'h6D};
        send_ttype(nm);
        send_ttype(nm);                 // same name again, no request
        send_cmd(tcs_pkg::WILL, tcs_pkg::FEAT_TTYPE);   // a name is stored, no request
        nm = '{8'h56, 8'h54, 8'h31, 8'h30, 8'h30};
        send_ttype(nm);
        nm = '{};
        for (int k = 0; k < 45; k++) nm.push_back(8'(8'h61 + k % 20));
        send_ttype(nm);
        nm[44] = 8'h5A;
        send_ttype(nm);                 // differs only past the stored depth
        nm = '{8'h41, tcs_pkg::IAC, 8'h42};
        send_ttype(nm);                 // escaped IAC inside the name
        nm = '{8'h51};
        send_ttype(nm);                 // one byte is too short
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SB); send_rx(tcs_pkg::FEAT_TTYPE);
        send_rx(tcs_pkg::TT_SEND);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SE);      // not an IS request
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SB); send_rx(tcs_pkg::FEAT_SGA);
        send_rx(8'h11);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SE);      // other feature is skipped
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SB); send_rx(tcs_pkg::FEAT_TTYPE);
        send_rx(tcs_pkg::TT_IS);
        send_rx(8'h51); send_rx(8'h52);
        send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::DO); send_rx(tcs_pkg::FEAT_SGA);   // broken end
    endtask

    task automatic test_keepalive();
        set_period(32'd0);
        send_item(1'b0, 8'h31, 1'b1);
        send_tick();
        send_item(1'b0, 8'h32, 1'b1);
        set_period(32'd2);
        repeat (2) send_tick();
        send_item(1'b0, 8'h33, 1'b1);
        repeat (3) send_tick();
        send_item(1'b0, 8'h34, 1'b1);
        set_period(32'hFFFF_FFFF);
        send_tick();
        send_item(1'b0, 8'h35, 1'b1);
    endtask

    task automatic test_random(input int count, input logic [31:0] ka);
        int stop;
        set_period(ka);
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 15) == 0) tx_busy_mode = ~tx_busy_mode;
            if ($urandom_range(0, 15) == 0) rx_busy_mode = ~rx_busy_mode;
            case ($urandom_range(0, 9))
                0, 1: send_rx(8'($urandom));
                2:    repeat ($urandom_range(1, 4)) send_tick();
                3, 4: send_cmd(8'($urandom_range(tcs_pkg::WILL, tcs_pkg::DONT)),
                               ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                               (($urandom_range(0, 2) == 0) ? tcs_pkg::FEAT_ECHO :
                               (($urandom_range(0, 1) == 0) ? tcs_pkg::FEAT_SGA :
                                tcs_pkg::FEAT_TTYPE)));
                5, 6: send_ttype(pick_name());
                7:    begin send_rx(tcs_pkg::IAC); send_rx(8'($urandom)); end
                8:    begin send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::IAC); end
                default: begin
                    if ($urandom_range(0, 3) == 0) drain();
                    send_rx(tcs_pkg::IAC); send_rx(tcs_pkg::SB); send_rx(8'($urandom));
                    repeat ($urandom_range(0, 4)) send_rx(8'($urandom));
                end
            endcase
        end
        tx_busy_mode = 1'b0;
        rx_busy_mode = 1'b0;
    endtask

    initial begin
        phase = tcs_pkg::PH_NORMAL;
        pend_cmd = 8'd0;
        sub_feat = 8'd0;
        sub_cnt = 8'd0;
        foreach (names[k]) names[k] = 8'd0;
        bank = 1'b0;
        name_len = 6'd0;
        same_name = 1'b1;
        pref_hit = 3'b111;
        ticks = 32'hFFFF_FFFF;
        incompat = 1'b0;
        period = 32'd5000;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_data_path();
        test_subnegotiation();
        test_negotiation();
        test_keepalive();
        test_random(70, 32'd3);
        test_random(70, 32'd0);
        test_random(70, 32'd5000);

        drain();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d items (bytes, ticks, commands, terminal names) and checked %0d",
                 items_sent, replies_seen);
        $display("result items over keepalive periods 0, 2, 3, 5000 and the maximum.");
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results never came", mismatches,
                     replies_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
